FILE: rtl/rthd_pkg.sv
// ----------------------------------------------------------------------------
// rthd_pkg
// Shared types and codes for the RTP H.264 depacketizer.
// ----------------------------------------------------------------------------
package rthd_pkg;

  // packet status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_ZERO_SIZE   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED   = 3'd4;

  // register indexes
  localparam logic REG_MAX_OUTPUT_LENGTH = 1'b0;

  // one queued job: what a single item expands into
  typedef struct packed {
    logic       start_code;  // emit 00 00 01 first
    logic       data_en;     // emit data byte
    logic [7:0] data;
    logic       eop;         // item closes the packet
    logic [2:0] status;
  } rthd_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rthd_qstat_t;

endpackage

FILE: rtl/rthd_front.sv
// ----------------------------------------------------------------------------
// rthd_front
// Header parser: classifies each byte; pushes a job on output or packet end.
// ----------------------------------------------------------------------------
module rthd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              last_byte,
  input  logic [15:0]       max_output_length,
  output logic              push,
  output rthd_pkg::rthd_job_t job
);
  import rthd_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_FU_HDR  = 3'd1;
  localparam logic [2:0] PH_BODY    = 3'd2;
  localparam logic [2:0] PH_SIZE_HI = 3'd3;
  localparam logic [2:0] PH_SIZE_LO = 3'd4;
  localparam logic [2:0] PH_UNIT    = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [1:0]  nri, nri_next;
  logic [7:0]  size_hi, size_hi_next;
  logic [15:0] unit_left, unit_left_next;
  logic [15:0] emitted, emitted_next;
  logic [2:0]  status, status_next;

  logic        sc, data_en;
  logic [7:0]  data;
  logic [16:0] limit, sum1, sum3, sum4;
  logic        ovf1, ovf3, ovf4;
  logic [15:0] unit_dec;

  function automatic logic [2:0] flag(input logic [2:0] cur, input logic [2:0] code);
    flag = (cur == ST_OK) ? code : cur;
  endfunction

  assign limit    = {1'b0, max_output_length};
  assign sum1     = {1'b0, emitted} + 17'd1;
  assign sum3     = {1'b0, emitted} + 17'd3;
  assign sum4     = {1'b0, emitted} + 17'd4;
  assign ovf1     = sum1 > limit;
  assign ovf3     = sum3 > limit;
  assign ovf4     = sum4 > limit;
  assign unit_dec = unit_left - 16'd1;

  always_comb begin
    phase_next     = phase;
    nri_next       = nri;
    size_hi_next   = size_hi;
    unit_left_next = unit_left;
    emitted_next   = emitted;
    status_next    = status;
    sc             = 1'b0;
    data_en        = 1'b0;
    data           = in_byte;

    unique case (phase)
      PH_HEADER: begin
        nri_next = in_byte[6:5];
        if (in_byte[4:0] == 5'd28) begin
          phase_next = PH_FU_HDR;
        end else if (in_byte[4:0] == 5'd24) begin
          phase_next = PH_SIZE_HI;
        end else if (in_byte[4:0] >= 5'd1 && in_byte[4:0] <= 5'd23) begin
          phase_next = PH_BODY;
          if (ovf3) begin
            status_next = flag(status, ST_OVERFLOW);
            phase_next  = PH_SKIP;
          end else if (ovf4) begin
            sc           = 1'b1;
            emitted_next = sum3[15:0];
            status_next  = flag(status, ST_OVERFLOW);
            phase_next   = PH_SKIP;
          end else begin
            sc           = 1'b1;
            data_en      = 1'b1;
            emitted_next = sum4[15:0];
          end
        end else begin
          status_next = flag(status, ST_UNSUPPORTED);
          phase_next  = PH_SKIP;
        end
      end
      PH_FU_HDR: begin
        phase_next = PH_BODY;
        // rebuilt nal header: nri of the indicator, type of the fu header
        data = {1'b0, nri, in_byte[4:0]};
        if (in_byte[7]) begin
          if (ovf3) begin
            status_next = flag(status, ST_OVERFLOW);
            phase_next  = PH_SKIP;
          end else if (ovf4) begin
            sc           = 1'b1;
            emitted_next = sum3[15:0];
            status_next  = flag(status, ST_OVERFLOW);
            phase_next   = PH_SKIP;
          end else begin
            sc           = 1'b1;
            data_en      = 1'b1;
            emitted_next = sum4[15:0];
          end
        end
      end
      PH_BODY: begin
        if (ovf1) begin
          status_next = flag(status, ST_OVERFLOW);
          phase_next  = PH_SKIP;
        end else begin
          data_en      = 1'b1;
          emitted_next = sum1[15:0];
        end
      end
      PH_SIZE_HI: begin
        size_hi_next = in_byte;
        phase_next   = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        unit_left_next = {size_hi, in_byte};
        if ({size_hi, in_byte} == 16'd0) begin
          status_next = flag(status, ST_ZERO_SIZE);
          phase_next  = PH_SKIP;
        end else if (ovf3) begin
          status_next = flag(status, ST_OVERFLOW);
          phase_next  = PH_SKIP;
        end else begin
          sc           = 1'b1;
          emitted_next = sum3[15:0];
          phase_next   = PH_UNIT;
        end
      end
      PH_UNIT: begin
        if (ovf1) begin
          status_next = flag(status, ST_OVERFLOW);
          phase_next  = PH_SKIP;
        end else begin
          data_en        = 1'b1;
          emitted_next   = sum1[15:0];
          unit_left_next = unit_dec;
          if (unit_dec == 16'd0) begin
            phase_next = PH_SIZE_HI;
          end
        end
      end
      default: begin
      end
    endcase

    if (last_byte) begin
      if (phase_next == PH_UNIT && unit_left_next != 16'd0) begin
        status_next = flag(status_next, ST_TRUNCATED);
      end
      if (phase_next == PH_FU_HDR) begin
        status_next = flag(status_next, ST_TRUNCATED);
      end
    end
  end

  assign push           = accept && (sc || data_en || last_byte);
  assign job.start_code = sc;
  assign job.data_en    = data_en;
  assign job.data       = data;
  assign job.eop        = last_byte;
  assign job.status     = status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      nri       <= 2'd0;
      size_hi   <= 8'd0;
      unit_left <= 16'd0;
      emitted   <= 16'd0;
      status    <= ST_OK;
    end else if (accept) begin
      if (last_byte) begin
        phase     <= PH_HEADER;
        nri       <= 2'd0;
        size_hi   <= 8'd0;
        unit_left <= 16'd0;
        emitted   <= 16'd0;
        status    <= ST_OK;
      end else begin
        phase     <= phase_next;
        nri       <= nri_next;
        size_hi   <= size_hi_next;
        unit_left <= unit_left_next;
        emitted   <= emitted_next;
        status    <= status_next;
      end
    end
  end

endmodule

FILE: rtl/rthd_queue.sv
// ----------------------------------------------------------------------------
// rthd_queue
// Small job queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module rthd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rthd_pkg::rthd_job_t push_job,
  input  logic                pop,
  output rthd_pkg::rthd_job_t head_job,
  output rthd_pkg::rthd_qstat_t qstat
);
  import rthd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rthd_job_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_job    = mem[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/rthd_back.sv
// ----------------------------------------------------------------------------
// rthd_back
// Result sequencer: expands jobs into results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module rthd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rthd_pkg::rthd_job_t  head_job,
  input  rthd_pkg::rthd_qstat_t qstat,
  output logic                 pop,
  input  logic                 res_stall,
  output logic                 res_valid,
  output logic [7:0]           out_byte,
  output logic                 byte_valid,
  output logic                 end_of_packet,
  output logic [2:0]           packet_status
);
  import rthd_pkg::*;

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       load;
  logic       is_last;
  logic [7:0] r_byte;
  logic       r_bvalid;

  // start code is three results, data byte one more, bare marker one
  always_comb begin
    priority if (head_job.start_code && head_job.data_en) last_idx = 2'd3;
    else if (head_job.start_code)                         last_idx = 2'd2;
    else                                                  last_idx = 2'd0;
  end

  always_comb begin
    if (head_job.start_code && idx != 2'd3) begin
      r_byte   = (idx == 2'd2) ? 8'h01 : 8'h00;
      r_bvalid = 1'b1;
    end else if (head_job.data_en) begin
      r_byte   = head_job.data;
      r_bvalid = 1'b1;
    end else begin
      r_byte   = 8'h00;
      r_bvalid = 1'b0;
    end
  end

  assign load    = !res_valid || !res_stall;
  assign is_last = (idx == last_idx);
  assign pop     = load && !qstat.empty && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      res_valid <= !qstat.empty;
      if (!qstat.empty) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !qstat.empty) begin
      out_byte      <= r_byte;
      byte_valid    <= r_bvalid;
      end_of_packet <= head_job.eop && is_last;
      packet_status <= head_job.status;
    end
  end

endmodule

FILE: rtl/rtp_h264_nal_depacketizer.sv
// ----------------------------------------------------------------------------
// rtp_h264_nal_depacketizer
// RTP H.264 payload to Annex-B byte stream converter.
// ----------------------------------------------------------------------------
// A payload byte is taken every cycle while the job queue has room. Each byte
// becomes zero to four stream results (a start code adds three), and the
// result side sends one result per cycle while res_stall is low, so the
// sequencer sets the rate; an item that opens a unit with its header byte
// gives four results. The parser runs ahead of the sequencer by up to
// QUEUE_DEPTH jobs, and item_stall rises only when that queue is full.
module rtp_h264_nal_depacketizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // payload side
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  // stream side
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        end_of_packet,
  output logic [2:0]  packet_status,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rthd_pkg::*;

  logic        accept;
  logic        push;
  logic        pop;
  rthd_job_t   push_job;
  rthd_job_t   head_job;
  rthd_qstat_t qstat;
  logic [15:0] max_output_length;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_length <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_MAX_OUTPUT_LENGTH) begin
      max_output_length <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_OUTPUT_LENGTH) ? {16'd0, max_output_length} : 32'd0;

  assign item_stall = qstat.full;
  assign accept     = item_valid && !item_stall;

  rthd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .in_byte           (in_byte),
    .last_byte         (last_byte),
    .max_output_length (max_output_length),
    .push              (push),
    .job               (push_job)
  );

  rthd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  rthd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_job      (head_job),
    .qstat         (qstat),
    .pop           (pop),
    .res_stall     (res_stall),
    .res_valid     (res_valid),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_packet (end_of_packet),
    .packet_status (packet_status)
  );

  // a bare marker only ever closes a packet
  a_marker_eop: assert property (@(posedge clk) disable iff (rst)
    res_valid && !byte_valid |-> end_of_packet)
    else $error("bare marker without end of packet");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !byte_valid |-> out_byte == 8'h00)
    else $error("bare marker carries a nonzero byte");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> packet_status <= ST_TRUNCATED)
    else $error("packet status out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("job queue popped while empty");

endmodule
